>>> rtl/core/jgc_pkg.sv
// jgc_pkg: shared types, direction and action codes for the joystick classifier
// no dependencies; imported by every module of the block
`default_nettype none

package jgc_pkg;

  typedef logic [2:0] dir_t;
  typedef logic [2:0] action_t;

  localparam dir_t DIR_NONE   = 3'd0;
  localparam dir_t DIR_UP     = 3'd1;
  localparam dir_t DIR_DOWN   = 3'd2;
  localparam dir_t DIR_LEFT   = 3'd3;
  localparam dir_t DIR_RIGHT  = 3'd4;
  localparam dir_t DIR_CENTER = 3'd5;

  localparam action_t ACT_NONE   = 3'd0;
  localparam action_t ACT_PREV   = 3'd1;
  localparam action_t ACT_NEXT   = 3'd2;
  localparam action_t ACT_LEFT   = 3'd3;
  localparam action_t ACT_RIGHT  = 3'd4;
  localparam action_t ACT_SELECT = 3'd5;
  localparam action_t ACT_MENU   = 3'd6;
  localparam action_t ACT_BACK   = 3'd7;

  // configuration register indexes
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t REG_LONG_PRESS = 2'd0;
  localparam cfg_idx_t REG_DEBOUNCE   = 2'd1;
  localparam cfg_idx_t REG_COOLDOWN   = 2'd2;
  localparam cfg_idx_t REG_LOCK_WIN   = 2'd3;

  localparam int unsigned CFG_DATA_W = 16;

  typedef struct packed {
    logic [15:0] long_press_ms;
    logic [9:0]  debounce_ms;
    logic [9:0]  cooldown_ms;
    logic [9:0]  lock_window_ms;
  } cfg_t;

  localparam logic [15:0] LONG_PRESS_RST = 16'd1000;
  localparam logic [9:0]  DEBOUNCE_RST   = 10'd50;
  localparam logic [9:0]  COOLDOWN_RST   = 10'd80;
  localparam logic [9:0]  LOCK_WIN_RST   = 10'd30;

  function automatic action_t click_action(input dir_t dir);
    action_t act;
    begin
      case (dir)
        DIR_UP:     act = ACT_PREV;
        DIR_DOWN:   act = ACT_NEXT;
        DIR_LEFT:   act = ACT_LEFT;
        DIR_RIGHT:  act = ACT_RIGHT;
        DIR_CENTER: act = ACT_SELECT;
        default:    act = ACT_NONE;
      endcase
      return act;
    end
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/jgc_cfg_regs.sv
// jgc_cfg_regs: the four timing registers behind the configuration write channel
// depends on jgc_pkg
`default_nettype none

module jgc_cfg_regs (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             wr_en,
  input  wire jgc_pkg::cfg_idx_t          wr_index,
  input  wire [jgc_pkg::CFG_DATA_W-1:0]   wr_data,
  output jgc_pkg::cfg_t                   cfg
);
  import jgc_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_press_ms  <= LONG_PRESS_RST;
      cfg_r.debounce_ms    <= DEBOUNCE_RST;
      cfg_r.cooldown_ms    <= COOLDOWN_RST;
      cfg_r.lock_window_ms <= LOCK_WIN_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_LONG_PRESS: cfg_r.long_press_ms  <= wr_data[15:0];
        REG_DEBOUNCE:   cfg_r.debounce_ms    <= wr_data[9:0];
        REG_COOLDOWN:   cfg_r.cooldown_ms    <= wr_data[9:0];
        REG_LOCK_WIN:   cfg_r.lock_window_ms <= wr_data[9:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> rtl/core/jgc_tracker.sv
// jgc_tracker: press, lock, long-press and cooldown state with the per-poll decision
// depends on jgc_pkg
`default_nettype none

module jgc_tracker (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     step,
  input  wire [31:0]              now_ms,
  input  wire jgc_pkg::dir_t      direction,
  input  wire jgc_pkg::cfg_t      cfg,
  output jgc_pkg::action_t        action,
  output logic                    stick_active
);
  import jgc_pkg::*;

  logic        press_active_r, press_active_nxt;
  logic [31:0] press_start_r, press_start_nxt;
  logic        long_sent_r, long_sent_nxt;
  dir_t        locked_dir_r, locked_dir_nxt;
  logic [31:0] cooldown_until_r, cooldown_until_nxt;
  logic        cooldown_valid_r, cooldown_valid_nxt;

  dir_t        dir_clean;
  dir_t        dir_masked;
  logic [31:0] cd_left;
  logic        cd_masking;
  logic [31:0] held;
  logic        in_lock;
  logic        long_due;
  action_t     act;

  assign cd_left    = cooldown_until_r - now_ms;
  // still cooling down while the distance to the end is nonzero and not in the past
  assign cd_masking = cooldown_valid_r && (cd_left != 32'd0) && !cd_left[31];
  assign held       = now_ms - press_start_r;
  assign in_lock    = held < {22'd0, cfg.lock_window_ms};
  assign long_due   = held >= {16'd0, cfg.long_press_ms};

  always_comb begin
    dir_clean  = (direction > DIR_CENTER) ? DIR_NONE : direction;
    dir_masked = cd_masking ? DIR_NONE : dir_clean;

    press_active_nxt   = press_active_r;
    press_start_nxt    = press_start_r;
    long_sent_nxt      = long_sent_r;
    locked_dir_nxt     = locked_dir_r;
    cooldown_until_nxt = cooldown_until_r;
    cooldown_valid_nxt = cooldown_valid_r && cd_masking;
    act                = ACT_NONE;

    if (dir_masked != DIR_NONE) begin
      if (!press_active_r) begin
        press_active_nxt = 1'b1;
        press_start_nxt  = now_ms;
        long_sent_nxt    = 1'b0;
        locked_dir_nxt   = dir_masked;
      end else if (!long_sent_r) begin
        if (in_lock) begin
          locked_dir_nxt = dir_masked;
        end else if (long_due) begin
          if (locked_dir_r == DIR_CENTER) begin
            act           = ACT_MENU;
            long_sent_nxt = 1'b1;
          end else if (locked_dir_r == DIR_LEFT) begin
            act           = ACT_BACK;
            long_sent_nxt = 1'b1;
          end
        end
      end
    end else if (press_active_r) begin
      // release: click only for a debounced press without a long press
      if ((held >= {22'd0, cfg.debounce_ms}) && !long_sent_r) begin
        act = click_action(locked_dir_r);
      end
      press_active_nxt   = 1'b0;
      long_sent_nxt      = 1'b0;
      locked_dir_nxt     = DIR_NONE;
      cooldown_until_nxt = now_ms + {22'd0, cfg.cooldown_ms};
      cooldown_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_active_r   <= 1'b0;
      press_start_r    <= 32'd0;
      long_sent_r      <= 1'b0;
      locked_dir_r     <= DIR_NONE;
      cooldown_until_r <= 32'd0;
      cooldown_valid_r <= 1'b0;
    end else if (step) begin
      press_active_r   <= press_active_nxt;
      press_start_r    <= press_start_nxt;
      long_sent_r      <= long_sent_nxt;
      locked_dir_r     <= locked_dir_nxt;
      cooldown_until_r <= cooldown_until_nxt;
      cooldown_valid_r <= cooldown_valid_nxt;
    end
  end

  assign action       = act;
  assign stick_active = (dir_masked != DIR_NONE);

  a_long_needs_press: assert property (@(posedge clk) disable iff (!rst_n)
    long_sent_r |-> press_active_r)
    else $error("long press flag set without an active press");

  a_locked_dir_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !press_active_r |-> (locked_dir_r == DIR_NONE))
    else $error("locked direction left over after release");

  a_locked_dir_held: assert property (@(posedge clk) disable iff (!rst_n)
    press_active_r |-> (locked_dir_r != DIR_NONE))
    else $error("active press with no locked direction");

  a_long_action_src: assert property (@(posedge clk) disable iff (!rst_n)
    (step && (act == ACT_MENU || act == ACT_BACK)) |=> long_sent_r)
    else $error("long press action without marking it sent");

  a_release_cooldown: assert property (@(posedge clk) disable iff (!rst_n)
    (step && press_active_r && !stick_active) |=> (cooldown_valid_r && !press_active_r))
    else $error("release did not start the cooldown");

endmodule

`default_nettype wire

>>> rtl/core/joystick_gesture_classifier.sv
// joystick_gesture_classifier: top level, input beat register, tracker, result register
// depends on jgc_pkg, jgc_cfg_regs, jgc_tracker
//
// channel | direction | payload
// --------+-----------+------------------------------------------------
// in_     | slave     | tdata[31:0] now_ms, [34:32] direction
// out_    | master    | tdata[2:0] action, [3] stick_active
// cfg_    | slave     | cfg_index 0..3, cfg_data[15:0], always ready
//
// one poll per cycle sustained while out_tready stays high; a beat is held in the input
// register, then its result is loaded into the output register when the result register
// is free or being drained. the tracker state updates in the same edge that loads the result.
// out_tready low holds the result and backs up into in_tready, no beat is lost.
// rst_n is synchronous; it clears control state and loads the register defaults.
`default_nettype none

module joystick_gesture_classifier (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_tvalid,
  output logic                           in_tready,
  input  wire [39:0]                     in_tdata,   // [31:0] now_ms, [34:32] direction
  output logic                           out_tvalid,
  input  wire                            out_tready,
  output logic [7:0]                     out_tdata,  // [2:0] action, [3] stick_active
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire jgc_pkg::cfg_idx_t         cfg_index,
  input  wire [jgc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import jgc_pkg::*;

  logic        in_valid_r;
  logic [31:0] now_r;
  dir_t        dir_r;
  logic        out_valid_r;
  action_t     action_r;
  logic        active_r;

  logic        step;
  cfg_t        cfg;
  action_t     action;
  logic        stick_active;

  // the held beat moves on when the result register is free or being drained
  assign step      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || step;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      now_r <= in_tdata[31:0];
      dir_r <= in_tdata[34:32];
    end
  end

  jgc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  jgc_tracker u_trk (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .now_ms       (now_r),
    .direction    (dir_r),
    .cfg          (cfg),
    .action       (action),
    .stick_active (stick_active)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      action_r <= action;
      active_r <= stick_active;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, active_r, action_r};

endmodule

`default_nettype wire
